// ===== rtl/core/enrp_pkg.sv =====
// ----------------------------------------------------------------------------
// enrp_pkg
// Types and constants of the escaped node record parser.
// ----------------------------------------------------------------------------
package enrp_pkg;

    localparam int unsigned HEADER_RESERVED_BYTES = 128;
    localparam logic [7:0]  ESCAPE_BYTE = 8'hFD;
    localparam logic [7:0]  NODE_OPEN   = 8'hFE;
    localparam logic [7:0]  NODE_CLOSE  = 8'hFF;
    localparam logic [15:0] HEADER_ATTR_SIZE = 16'd140;
    localparam logic [7:0]  ATTR_SERVER = 8'h10;
    localparam logic [7:0]  ATTR_CLIENT = 8'h11;
    localparam logic [7:0]  ATTR_SPEED  = 8'h14;
    localparam logic [7:0]  ATTR_LIGHT  = 8'h2A;
    localparam logic [7:0]  ATTR_TOP    = 8'h2B;

    localparam logic [1:0] KIND_RECORD  = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_VER    = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
    localparam logic [2:0] ST_TRUNC      = 3'd4;
    localparam logic [2:0] ST_UNEXP_END  = 3'd5;

    localparam logic [0:0] CFG_FORMAT = 1'd0;
    localparam logic [0:0] CFG_CLIENT = 1'd1;

    typedef enum logic [4:0] {
        PH_H0 = 5'd0, PH_H1 = 5'd1, PH_H2 = 5'd2, PH_H3 = 5'd3, PH_H4 = 5'd4,
        PH_H5 = 5'd5, PH_FMT = 5'd6, PH_CLI = 5'd7, PH_DUP = 5'd8,
        PH_RSV = 5'd9, PH_NODE = 5'd10, PH_NTYPE = 5'd11, PH_NFLAGS = 5'd12,
        PH_ACODE = 5'd13, PH_ASZ = 5'd14, PH_AVAL = 5'd15, PH_DONE = 5'd16
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  status;
        logic [31:0] item_flags;
        logic [7:0]  node_type;
        logic [15:0] srv_id;
        logic [15:0] clnt_id;
        logic [15:0] speed;
        logic [15:0] lamp_level;
        logic [15:0] lamp_hue;
        logic [7:0]  top_rank;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_slot_t;

    function automatic logic [15:0] hdr_width(input phase_t ph);
        case (ph)
            PH_H0, PH_H3, PH_FMT, PH_CLI, PH_DUP: hdr_width = 16'd4;
            PH_H5:                               hdr_width = 16'd2;
            default:                             hdr_width = 16'd1;
        endcase
    endfunction

    function automatic logic [31:0] hdr_expect(input phase_t ph);
        case (ph)
            PH_H1:   hdr_expect = {24'd0, NODE_OPEN};
            PH_H4:   hdr_expect = 32'd1;
            PH_H5:   hdr_expect = {16'd0, HEADER_ATTR_SIZE};
            default: hdr_expect = 32'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/escaped_node_record_parser.sv =====
// ----------------------------------------------------------------------------
// escaped_node_record_parser
// Unescapes a node file byte stream, checks header, emits item records,
// error results and a maxima summary at end of file.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_data  (in_item_t)
// out     | out | out_valid / out_ready | out_data (out_item_t)
// cfg     | in  | cfg_we                | cfg_index, cfg_wdata
//
// One byte per cycle while in_ready is high; each transfer updates the parse
// registers and pushes zero to two results into a four-entry result queue.
// in_ready drops while the queue holds more than two results.
// Reset restores the header phase and the reset register values.
// ----------------------------------------------------------------------------
module escaped_node_record_parser
    import enrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    logic [31:0] efmt_reg, ecli_reg;
    logic        esc_reg, esc_next;
    phase_t      ph_reg, ph_next;
    logic [15:0] bc_reg, bc_next;
    logic [31:0] fs_reg, fs_next;
    logic [7:0]  ac_reg, ac_next;
    logic [15:0] as_reg, as_next;
    logic [31:0] fv_reg, fv_next;
    logic [31:0] cf_reg, cf_next;
    logic [7:0]  ct_reg, ct_next;
    logic [15:0] cv_reg [6];
    logic [15:0] cv_next [6];
    logic [15:0] mx_reg [6];
    logic [15:0] mx_next [6];
    logic        lbe_reg, lbe_next;
    logic        err_reg, err_next;

    res_slot_t   p0, p1;
    logic        take;
    logic [7:0]  b;
    logic        deliver;
    logic [15:0] bc_inc;
    logic [31:0] fs_acc;
    logic [15:0] req;
    logic [2:0]  st;

    assign take = in_valid && in_ready;
    assign b    = in_data.byte_in;
    assign bc_inc = bc_reg + 16'd1;
    assign fs_acc = fs_reg | ({24'd0, b} << {bc_reg[1:0], 3'b000});

    always_comb
    begin
        case (ac_reg)
            ATTR_SERVER, ATTR_CLIENT, ATTR_SPEED: req = 16'd2;
            ATTR_LIGHT: req = 16'd4;
            ATTR_TOP:   req = 16'd1;
            default:    req = 16'd0;
        endcase
    end

    always_comb
    begin
        esc_next = esc_reg;
        ph_next = ph_reg;
        bc_next = bc_reg;
        fs_next = fs_reg;
        ac_next = ac_reg;
        as_next = as_reg;
        fv_next = fv_reg;
        cf_next = cf_reg;
        ct_next = ct_reg;
        cv_next = cv_reg;
        mx_next = mx_reg;
        lbe_next = lbe_reg;
        err_next = err_reg;
        p0 = '0;
        p1 = '0;
        st = ST_OK;
        deliver = 1'b0;
        if (esc_reg)
        begin
            esc_next = 1'b0;
            deliver = 1'b1;
        end
        else if (b == ESCAPE_BYTE)
            esc_next = 1'b1;
        else
            deliver = 1'b1;

        if (deliver && !err_reg)
        begin
            if (ph_reg <= PH_DUP)
            begin
                fs_next = fs_acc;
                bc_next = bc_inc;
                if (bc_inc == hdr_width(ph_reg))
                begin
                    bc_next = '0;
                    fs_next = '0;
                    ph_next = phase_t'(ph_reg + 5'd1);
                    if (ph_reg == PH_DUP && HEADER_RESERVED_BYTES == 0)
                        ph_next = PH_NODE;
                    if (ph_reg < PH_FMT && fs_acc != hdr_expect(ph_reg))
                    begin
                        p0.valid = 1'b1;
                        p0.item.result_kind = KIND_ERROR;
                        p0.item.status = ST_BAD_HEADER;
                        err_next = 1'b1;
                        ph_next = ph_reg;
                        bc_next = bc_inc;
                        fs_next = fs_acc;
                    end
                    else if (ph_reg == PH_FMT)
                        fv_next = fs_acc;
                    else if (ph_reg == PH_CLI && fv_reg != efmt_reg && fs_acc != ecli_reg)
                    begin
                        p0.valid = 1'b1;
                        p0.item.result_kind = KIND_ERROR;
                        p0.item.status = ST_BAD_VER;
                        err_next = 1'b1;
                        ph_next = ph_reg;
                        bc_next = bc_inc;
                        fs_next = fs_acc;
                    end
                end
            end
            else
            begin
                case (ph_reg)
                    PH_RSV:
                    begin
                        bc_next = bc_inc;
                        if (bc_inc >= 16'(HEADER_RESERVED_BYTES))
                        begin
                            ph_next = PH_NODE;
                            bc_next = '0;
                            fs_next = '0;
                        end
                    end
                    PH_NODE:
                    begin
                        if (b == NODE_OPEN)
                        begin
                            for (int i = 0; i < 6; i++)
                                cv_next[i] = '0;
                            cf_next = '0;
                            ct_next = '0;
                            ph_next = PH_NTYPE;
                            bc_next = '0;
                            fs_next = '0;
                        end
                        else
                        begin
                            lbe_next = (b == NODE_CLOSE);
                            ph_next = PH_DONE;
                        end
                    end
                    PH_NTYPE:
                    begin
                        ct_next = b;
                        ph_next = PH_NFLAGS;
                        bc_next = '0;
                        fs_next = '0;
                    end
                    PH_NFLAGS:
                    begin
                        fs_next = fs_acc;
                        bc_next = bc_inc;
                        if (bc_inc == 16'd4)
                        begin
                            cf_next = fs_acc;
                            ph_next = PH_ACODE;
                            bc_next = '0;
                            fs_next = '0;
                        end
                    end
                    PH_ACODE:
                    begin
                        if (b == NODE_CLOSE)
                        begin
                            for (int i = 0; i < 6; i++)
                                if (cv_reg[i] > mx_reg[i])
                                    mx_next[i] = cv_reg[i];
                            p0.valid = 1'b1;
                            p0.item.result_kind = KIND_RECORD;
                            p0.item.item_flags = cf_reg;
                            p0.item.node_type = ct_reg;
                            p0.item.srv_id = cv_reg[0];
                            p0.item.clnt_id = cv_reg[1];
                            p0.item.speed = cv_reg[2];
                            p0.item.lamp_level = cv_reg[3];
                            p0.item.lamp_hue = cv_reg[4];
                            p0.item.top_rank = cv_reg[5][7:0];
                            ph_next = PH_NODE;
                        end
                        else
                        begin
                            ac_next = b;
                            ph_next = PH_ASZ;
                        end
                        bc_next = '0;
                        fs_next = '0;
                    end
                    PH_ASZ:
                    begin
                        fs_next = fs_acc;
                        bc_next = bc_inc;
                        if (bc_inc == 16'd2)
                        begin
                            as_next = fs_acc[15:0];
                            if (req != 16'd0 && fs_acc[15:0] != req)
                            begin
                                p0.valid = 1'b1;
                                p0.item.result_kind = KIND_ERROR;
                                p0.item.status = ST_BAD_SIZE;
                                err_next = 1'b1;
                            end
                            else
                            begin
                                ph_next = (fs_acc[15:0] == 16'd0) ? PH_ACODE : PH_AVAL;
                                bc_next = '0;
                                fs_next = '0;
                            end
                        end
                    end
                    PH_AVAL:
                    begin
                        fs_next = fs_acc;
                        bc_next = bc_inc;
                        if (bc_inc >= as_reg)
                        begin
                            case (ac_reg)
                                ATTR_SERVER: cv_next[0] = fs_acc[15:0];
                                ATTR_CLIENT: cv_next[1] = fs_acc[15:0];
                                ATTR_SPEED:  cv_next[2] = fs_acc[15:0];
                                ATTR_LIGHT:
                                begin
                                    cv_next[3] = fs_acc[15:0];
                                    cv_next[4] = fs_acc[31:16];
                                end
                                ATTR_TOP:    cv_next[5] = {8'd0, fs_acc[7:0]};
                                default: ;
                            endcase
                            ph_next = PH_ACODE;
                            bc_next = '0;
                            fs_next = '0;
                        end
                    end
                    default:
                    begin
                        lbe_next = 1'b0;
                        ph_next = PH_DONE;
                    end
                endcase
            end
        end

        if (in_data.end_of_file)
        begin
            if (!err_next)
            begin
                p1.valid = 1'b1;
                if (ph_next < PH_DUP)
                begin
                    p1.item.result_kind = KIND_ERROR;
                    p1.item.status = ST_BAD_HEADER;
                end
                else
                begin
                    if (ph_next == PH_NODE)
                        st = ST_UNEXP_END;
                    else if (ph_next >= PH_DONE)
                        st = lbe_next ? ST_OK : ST_UNEXP_END;
                    else
                        st = ST_TRUNC;
                    p1.item.result_kind = KIND_SUMMARY;
                    p1.item.status = st;
                    p1.item.srv_id = mx_next[0];
                    p1.item.clnt_id = mx_next[1];
                    p1.item.speed = mx_next[2];
                    p1.item.lamp_level = mx_next[3];
                    p1.item.lamp_hue = mx_next[4];
                    p1.item.top_rank = mx_next[5][7:0];
                end
            end
            esc_next = 1'b0;
            ph_next = PH_H0;
            bc_next = '0;
            fs_next = '0;
            ac_next = '0;
            as_next = '0;
            fv_next = '0;
            cf_next = '0;
            ct_next = '0;
            for (int i = 0; i < 6; i++)
            begin
                cv_next[i] = '0;
                mx_next[i] = '0;
            end
            lbe_next = 1'b0;
            err_next = 1'b0;
        end
        if (p1.valid)
            p1.item.last = 1'b1;
        else if (p0.valid)
            p0.item.last = 1'b1;
        if (!take)
        begin
            p0.valid = 1'b0;
            p1.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            efmt_reg <= 32'd3;
            ecli_reg <= 32'd23;
            esc_reg <= 1'b0;
            ph_reg <= PH_H0;
            bc_reg <= '0;
            fs_reg <= '0;
            ac_reg <= '0;
            as_reg <= '0;
            fv_reg <= '0;
            cf_reg <= '0;
            ct_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                cv_reg[i] <= '0;
                mx_reg[i] <= '0;
            end
            lbe_reg <= 1'b0;
            err_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FORMAT)
                efmt_reg <= cfg_wdata;
            if (cfg_we && cfg_index == CFG_CLIENT)
                ecli_reg <= cfg_wdata;
            if (take)
            begin
                esc_reg <= esc_next;
                ph_reg <= ph_next;
                bc_reg <= bc_next;
                fs_reg <= fs_next;
                ac_reg <= ac_next;
                as_reg <= as_next;
                fv_reg <= fv_next;
                cf_reg <= cf_next;
                ct_reg <= ct_next;
                cv_reg <= cv_next;
                mx_reg <= mx_next;
                lbe_reg <= lbe_next;
                err_reg <= err_next;
            end
        end
    end

    enrp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (p0),
        .push1     (p1),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

// ===== rtl/core/enrp_out_queue.sv =====
// ----------------------------------------------------------------------------
// enrp_out_queue
// Result queue: takes up to two results per byte and delivers one per transfer.
// ----------------------------------------------------------------------------
module enrp_out_queue
    import enrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_slot_t push0,
    input  res_slot_t push1,
    output logic      can_push,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    out_item_t  mem_reg [4];
    logic [1:0] rd_reg, wr_reg, rd_next, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] npush;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign can_push  = (cnt_reg <= 3'd2);
    assign npush     = {1'b0, push0.valid} + {1'b0, push1.valid};

    always_comb
    begin
        rd_next  = rd_reg + {1'b0, pop};
        wr_next  = wr_reg + npush;
        cnt_next = cnt_reg + {1'b0, npush} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0.valid)
            mem_reg[wr_reg] <= push0.item;
        if (push1.valid)
            mem_reg[push0.valid ? wr_reg + 2'd1 : wr_reg] <= push1.item;
    end
endmodule

// ===== sim/escaped_node_record_parser_tb.sv =====
// ----------------------------------------------------------------------------
// escaped_node_record_parser_tb
// Sends escaped node files through the parser and compares every record,
// summary and error against a cycle-free model of the byte parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module escaped_node_record_parser_tb;
    import enrp_pkg::*;

    localparam int WD_LIMIT = 2000;
    localparam int HDR_W [9] = '{4, 1, 1, 4, 1, 2, 4, 4, 4};
    localparam logic [31:0] HDR_V [6] = '{0, 32'hFE, 0, 0, 1, 140};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_FORMAT;
    logic [31:0] cfg_wdata = '0;

    escaped_node_record_parser i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser model state
    logic [31:0] want_fmt = 32'd3, want_cli = 32'd23;
    bit          esc_pend, got_error, ended_on_close;
    phase_t      phase;
    logic [15:0] nbytes, attr_len;
    logic [31:0] shreg, fmt_seen, cur_flags;
    logic [7:0]  attr_id, cur_type;
    logic [15:0] cur_val [6];
    logic [15:0] max_val [6];

    out_item_t   expected_results[$];
    out_item_t   step_results[$];
    int          n_sent = 0;
    int          n_err = 0;
    bit          no_idle = 1'b0;

    function automatic void clear_parser();
        esc_pend = 0; got_error = 0; ended_on_close = 0;
        phase = PH_H0; nbytes = 0; attr_len = 0; shreg = 0; fmt_seen = 0;
        cur_flags = 0; attr_id = 0; cur_type = 0;
        for (int i = 0; i < 6; i++)
        begin
            cur_val[i] = 0;
            max_val[i] = 0;
        end
    endfunction

    function automatic void put(logic [1:0] kind, logic [2:0] st, int src);
        out_item_t r;
        logic [15:0] v [6];
        r = '0;
        r.result_kind = kind;
        r.status = st;
        for (int i = 0; i < 6; i++)
            v[i] = (src == 1) ? cur_val[i] : (src == 2) ? max_val[i] : 16'd0;
        if (src == 1)
        begin
            r.item_flags = cur_flags;
            r.node_type = cur_type;
        end
        r.srv_id = v[0]; r.clnt_id = v[1]; r.speed = v[2];
        r.lamp_level = v[3]; r.lamp_hue = v[4]; r.top_rank = v[5][7:0];
        step_results.push_back(r);
    endfunction

    function automatic void fail_file(logic [2:0] st);
        put(KIND_ERROR, st, 0);
        got_error = 1;
    endfunction

    function automatic void take(logic [7:0] b);
        shreg = shreg | (32'(b) << (8 * nbytes[1:0]));
        nbytes = nbytes + 1;
    endfunction

    function automatic void next_field(phase_t p);
        phase = p;
        nbytes = 0;
        shreg = 0;
    endfunction

    function automatic int size_needed(logic [7:0] c);
        case (c)
            ATTR_SERVER, ATTR_CLIENT, ATTR_SPEED: return 2;
            ATTR_LIGHT: return 4;
            ATTR_TOP:   return 1;
            default:    return 0;
        endcase
    endfunction

    function automatic void parse(logic [7:0] b);
        int need;
        if (phase <= PH_DUP)
        begin
            take(b);
            if (nbytes != HDR_W[phase])
                return;
            if (phase < PH_FMT && shreg != HDR_V[phase])
            begin
                fail_file(ST_BAD_HEADER);
                return;
            end
            if (phase == PH_FMT)
                fmt_seen = shreg;
            if (phase == PH_CLI && fmt_seen != want_fmt && shreg != want_cli)
            begin
                fail_file(ST_BAD_VER);
                return;
            end
            next_field(phase == PH_DUP ? PH_RSV : phase_t'(phase + 1));
            return;
        end
        case (phase)
            PH_RSV:
            begin
                nbytes = nbytes + 1;
                if (nbytes >= HEADER_RESERVED_BYTES)
                    next_field(PH_NODE);
            end
            PH_NODE:
                if (b == NODE_OPEN)
                begin
                    for (int i = 0; i < 6; i++)
                        cur_val[i] = 0;
                    cur_flags = 0;
                    cur_type = 0;
                    next_field(PH_NTYPE);
                end
                else
                begin
                    ended_on_close = (b == NODE_CLOSE);
                    phase = PH_DONE;
                end
            PH_NTYPE:
            begin
                cur_type = b;
                next_field(PH_NFLAGS);
            end
            PH_NFLAGS:
            begin
                take(b);
                if (nbytes == 4)
                begin
                    cur_flags = shreg;
                    next_field(PH_ACODE);
                end
            end
            PH_ACODE:
                if (b == NODE_CLOSE)
                begin
                    for (int i = 0; i < 6; i++)
                        if (cur_val[i] > max_val[i])
                            max_val[i] = cur_val[i];
                    put(KIND_RECORD, ST_OK, 1);
                    next_field(PH_NODE);
                end
                else
                begin
                    attr_id = b;
                    next_field(PH_ASZ);
                end
            PH_ASZ:
            begin
                take(b);
                if (nbytes == 2)
                begin
                    attr_len = shreg[15:0];
                    need = size_needed(attr_id);
                    if (need != 0 && attr_len != need)
                        fail_file(ST_BAD_SIZE);
                    else if (attr_len == 0)
                        next_field(PH_ACODE);
                    else
                        next_field(PH_AVAL);
                end
            end
            PH_AVAL:
            begin
                take(b);
                if (nbytes >= attr_len)
                begin
                    case (attr_id)
                        ATTR_SERVER: cur_val[0] = shreg[15:0];
                        ATTR_CLIENT: cur_val[1] = shreg[15:0];
                        ATTR_SPEED:  cur_val[2] = shreg[15:0];
                        ATTR_LIGHT:
                        begin
                            cur_val[3] = shreg[15:0];
                            cur_val[4] = shreg[31:16];
                        end
                        ATTR_TOP:    cur_val[5] = {8'd0, shreg[7:0]};
                        default: ;
                    endcase
                    next_field(PH_ACODE);
                end
            end
            default:
            begin
                ended_on_close = 0;
                phase = PH_DONE;
            end
        endcase
    endfunction

    function automatic void predict_transfer(logic [7:0] b, bit eof);
        bit deliver;
        logic [2:0] st;
        deliver = 0;
        if (esc_pend)
        begin
            esc_pend = 0;
            deliver = 1;
        end
        else if (b == ESCAPE_BYTE)
            esc_pend = 1;
        else
            deliver = 1;
        if (deliver && !got_error)
            parse(b);
        if (eof)
        begin
            if (!got_error)
            begin
                if (phase < PH_DUP)
                    put(KIND_ERROR, ST_BAD_HEADER, 0);
                else
                begin
                    if (phase == PH_NODE)
                        st = ST_UNEXP_END;
                    else if (phase >= PH_DONE)
                        st = ended_on_close ? ST_OK : ST_UNEXP_END;
                    else
                        st = ST_TRUNC;
                    put(KIND_SUMMARY, st, 2);
                end
            end
            clear_parser();
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        while (step_results.size() > 0)
            expected_results.push_back(step_results.pop_front());
    endfunction

    // ---- stimulus helpers ----
    task automatic send_byte(logic [7:0] b, bit eof);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= in_item_t'{byte_in: b, end_of_file: eof};
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        predict_transfer(b, eof);
        n_sent++;
    endtask

    task automatic send_file(logic [7:0] f[$], bit trail_esc);
        int n;
        n = f.size();
        for (int i = 0; i < n; i++)
        begin
            if (f[i] == ESCAPE_BYTE || $urandom_range(0, 7) == 0)
                send_byte(ESCAPE_BYTE, 1'b0);
            send_byte(f[i], !trail_esc && i == n - 1);
        end
        if (trail_esc)
            send_byte(ESCAPE_BYTE, 1'b1);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FORMAT)
            want_fmt = val;
        else
            want_cli = val;
    endtask

    function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(v[8*i +: 8]);
    endfunction

    // bad_field selects a fixed header field to corrupt, -1 for none
    function automatic void add_header(ref logic [7:0] q[$], input logic [31:0] fmt,
                                       input logic [31:0] cli, input int bad_field);
        logic [31:0] v;
        for (int k = 0; k < 6; k++)
        begin
            v = HDR_V[k];
            if (k == bad_field)
                v = v ^ (32'd1 << $urandom_range(0, 8 * HDR_W[k] - 1));
            push_le(q, v, HDR_W[k]);
        end
        push_le(q, fmt, 4);
        push_le(q, cli, 4);
        push_le(q, $urandom, 4);
        for (int i = 0; i < HEADER_RESERVED_BYTES; i++)
            q.push_back($urandom_range(0, 255));
    endfunction

    function automatic void add_attr(ref logic [7:0] q[$], input logic [7:0] c,
                                     input int len);
        q.push_back(c);
        push_le(q, len, 2);
        for (int i = 0; i < len; i++)
            q.push_back($urandom_range(0, 255));
    endfunction

    function automatic void add_node(ref logic [7:0] q[$], input int nattr, input bit sizes_ok);
        logic [7:0] codes [6] = '{ATTR_SERVER, ATTR_CLIENT, ATTR_SPEED, ATTR_LIGHT,
                                  ATTR_TOP, 8'h00};
        logic [7:0] c;
        int len;
        q.push_back(NODE_OPEN);
        q.push_back($urandom_range(0, 255));
        push_le(q, $urandom, 4);
        for (int a = 0; a < nattr; a++)
        begin
            c = codes[$urandom_range(0, 5)];
            if (c == 8'h00)
                c = $urandom_range(0, 8'hFE);
            len = size_needed(c);
            if (len == 0)
                len = $urandom_range(0, 6);
            else if (!sizes_ok && $urandom_range(0, 2) == 0)
                len = $urandom_range(0, 1) ? 0 : 16'hFFFF;
            if (len == 16'hFFFF)
            begin
                q.push_back(c);
                push_le(q, len, 2);
            end
            else
                add_attr(q, c, len);
        end
        q.push_back(NODE_CLOSE);
    endfunction

    // ---- tests ----
    task automatic test_header_fields();
        logic [7:0] f[$];
        for (int k = 0; k < 6; k++)
        begin
            f = {};
            add_header(f, want_fmt, want_cli, k);
            f = f[0:20];
            send_file(f, 0);
        end
        f = {};
        add_header(f, want_fmt, want_cli, -1);
        send_file(f[0:8], 0);
        send_file(f[0:27], 0);
        send_file(f[0:30], 0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_versions();
        logic [31:0] vals [4] = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd23};
        logic [7:0] f[$];
        for (int i = 0; i < 2; i++)
        begin
            write_reg(CFG_FORMAT, vals[i]);
            write_reg(CFG_CLIENT, vals[3 - i]);
            for (int m = 0; m < 4; m++)
            begin
                f = {};
                add_header(f, m[0] ? want_fmt : ~want_fmt, m[1] ? want_cli : ~want_cli, -1);
                send_file(f[0:23], 0);
            end
        end
    endtask

    task automatic test_nodes();
        logic [7:0] f[$];
        no_idle = 1'b1;
        f = {};
        add_header(f, want_fmt, want_cli, -1);
        f.push_back(NODE_OPEN);
        f.push_back(8'hFD);
        push_le(f, 32'hFFFF_FFFF, 4);
        add_attr(f, ATTR_SERVER, 2);
        add_attr(f, ATTR_CLIENT, 2);
        add_attr(f, ATTR_SPEED, 2);
        add_attr(f, ATTR_LIGHT, 4);
        add_attr(f, ATTR_TOP, 1);
        add_attr(f, ATTR_SERVER, 2);
        add_attr(f, 8'h33, 3);
        add_attr(f, 8'h34, 0);
        f.push_back(NODE_CLOSE);
        f.push_back(NODE_OPEN);
        f.push_back(8'h00);
        push_le(f, 32'd0, 4);
        f.push_back(NODE_CLOSE);
        f.push_back(NODE_CLOSE);
        send_file(f, 0);
        send_file(f, 1);
        no_idle = 1'b0;
        f.push_back(NODE_OPEN);
        send_file(f, 0);
        f = f[0:f.size() - 3];
        send_file(f, 0);
    endtask

    task automatic test_random();
        logic [7:0] f[$];
        int cut, nn;
        while (n_sent < 1500)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_FORMAT, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 3));
                write_reg(CFG_CLIENT, $urandom_range(0, 2) == 0 ? 32'hFFFF_FFFF : $urandom);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            f = {};
            add_header(f, $urandom_range(0, 4) != 0 ? want_fmt : $urandom,
                       $urandom_range(0, 4) != 0 ? want_cli : $urandom,
                       $urandom_range(0, 14) == 0 ? $urandom_range(0, 5) : -1);
            nn = $urandom_range(0, 4);
            for (int i = 0; i < nn; i++)
                add_node(f, $urandom_range(0, 6), $urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0: f.push_back($urandom_range(0, 255));
                1:
                begin
                    f.push_back(NODE_CLOSE);
                    f.push_back($urandom_range(0, 255));
                end
                2:
                begin
                    cut = $urandom_range(1, f.size());
                    f = f[0:cut - 1];
                end
                default: f.push_back(NODE_CLOSE);
            endcase
            send_file(f, $urandom_range(0, 7) == 0);
        end
    endtask

    // ---- result side ----
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result transfer: %p", out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data !== want)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WD_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_fields();
        test_versions();
        test_nodes();
        test_random();
        in_valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
